### rtl/xalu_pkg.sv
`timescale 1ns / 1ps
// shared types, codes and helper functions for the x86 integer alu
// no dependencies
package xalu_pkg;

    localparam int DATA_BITS = 32;
    localparam int DIV_STEPS = DATA_BITS;
    localparam int Q_DEPTH   = 4;
    localparam int Q_PTR_W   = $clog2(Q_DEPTH);
    localparam int Q_CNT_W   = Q_PTR_W + 1;

    typedef logic [3:0] t_kind;
    localparam t_kind K_ADD    = 4'd0;
    localparam t_kind K_ADC    = 4'd1;
    localparam t_kind K_SUB    = 4'd2;
    localparam t_kind K_SBB    = 4'd3;
    localparam t_kind K_CMP    = 4'd4;
    localparam t_kind K_INC    = 4'd5;
    localparam t_kind K_DEC    = 4'd6;
    localparam t_kind K_NEG    = 4'd7;
    localparam t_kind K_MUL    = 4'd8;
    localparam t_kind K_IMUL_W = 4'd9;
    localparam t_kind K_IMUL_T = 4'd10;
    localparam t_kind K_DIV    = 4'd11;
    localparam t_kind K_IDIV   = 4'd12;

    typedef logic [1:0] t_wc;
    localparam t_wc WC_8  = 2'd0;
    localparam t_wc WC_16 = 2'd1;
    localparam t_wc WC_32 = 2'd2;

    // flag bit positions
    localparam int F_CF = 0;
    localparam int F_PF = 1;
    localparam int F_AF = 2;
    localparam int F_ZF = 3;
    localparam int F_SF = 4;
    localparam int F_OF = 5;

    typedef struct packed {
        t_kind                kind;
        t_wc                  width_code;
        logic [DATA_BITS-1:0] dest_value;
        logic [DATA_BITS-1:0] src_value;
        logic [DATA_BITS-1:0] high_value;
        logic [5:0]           flags_in;
    } t_alu_in;

    typedef struct packed {
        logic [DATA_BITS-1:0] result_low;
        logic [DATA_BITS-1:0] result_high;
        logic [5:0]           flags_out;
        logic                 writes_result;
        logic                 writes_high;
        logic                 divide_error;
    } t_alu_out;

    // classified item as it sits in the queue
    typedef struct packed {
        t_kind                kind;
        t_wc                  wc;
        logic [DATA_BITS-1:0] a;
        logic [DATA_BITS-1:0] b;
        logic [DATA_BITS-1:0] h;
        logic [5:0]           fin;
    } t_op;

    function automatic logic [DATA_BITS-1:0] wmask(t_wc wc);
        logic [DATA_BITS-1:0] m;
        unique case (wc)
            WC_8:    m = DATA_BITS'(32'h0000_00FF);
            WC_16:   m = DATA_BITS'(32'h0000_FFFF);
            default: m = '1;
        endcase
        return m;
    endfunction

    function automatic logic msb_of(logic [DATA_BITS-1:0] v, t_wc wc);
        logic s;
        unique case (wc)
            WC_8:    s = v[7];
            WC_16:   s = v[15];
            default: s = v[DATA_BITS-1];
        endcase
        return s;
    endfunction

    function automatic logic [DATA_BITS-1:0] sext_w(logic [DATA_BITS-1:0] v, t_wc wc);
        logic [DATA_BITS-1:0] r;
        unique case (wc)
            WC_8:    r = {{(DATA_BITS-8){v[7]}}, v[7:0]};
            WC_16:   r = {{(DATA_BITS-16){v[15]}}, v[15:0]};
            default: r = v;
        endcase
        return r;
    endfunction

endpackage

### rtl/xalu_front.sv
`timescale 1ns / 1ps
// front stage: accepts items, normalizes width and masks operands
// depends on xalu_pkg
module xalu_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  xalu_pkg::t_alu_in i_item,
    output logic              o_valid,
    input  logic              i_stall,
    output xalu_pkg::t_op     o_op
);
    import xalu_pkg::*;

    logic                 r_valid;
    t_op                  r_op;
    t_op                  n_op;
    logic [DATA_BITS-1:0] m;

    always_comb begin
        n_op.kind = i_item.kind;
        // unused width code runs as full width
        n_op.wc   = (i_item.width_code == WC_8 || i_item.width_code == WC_16) ?
                    i_item.width_code : WC_32;
        m         = wmask(n_op.wc);
        n_op.a    = i_item.dest_value & m;
        n_op.b    = i_item.src_value & m;
        n_op.h    = i_item.high_value & m;
        n_op.fin  = i_item.flags_in;
    end

    assign o_stall = r_valid && i_stall;
    assign o_valid = r_valid;
    assign o_op    = r_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_op <= n_op;
        end
    end

endmodule

### rtl/xalu_queue.sv
`timescale 1ns / 1ps
// short queue of classified items between front and back
// depends on xalu_pkg
module xalu_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  xalu_pkg::t_op i_op,
    output logic          o_valid,
    input  logic          i_pop,
    output xalu_pkg::t_op o_op
);
    import xalu_pkg::*;

    t_op                r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr;
    logic [Q_PTR_W-1:0] r_rd;
    logic [Q_CNT_W-1:0] r_count;
    logic               push;

    assign o_stall = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_op    = r_mem[r_rd];
    assign push    = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + Q_PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + Q_PTR_W'(1);
            end
            r_count <= r_count + Q_CNT_W'(push) - Q_CNT_W'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_op;
        end
    end

endmodule

### rtl/xalu_back.sv
`timescale 1ns / 1ps
// back end: alu, multiplier and one-bit-per-stage divide pipeline
// depends on xalu_pkg
module xalu_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_pop,
    input  xalu_pkg::t_op      i_op,
    output logic               o_valid,
    input  logic               i_stall,
    output xalu_pkg::t_alu_out o_item
);
    import xalu_pkg::*;

    typedef struct packed {
        t_kind                kind;
        t_wc                  wc;
        logic [DATA_BITS-1:0] lo;
        logic [DATA_BITS-1:0] hi;
        logic [DATA_BITS-1:0] dv;
        logic [5:0]           flags;
        logic                 wr;
        logic                 wh;
        logic                 de;
        logic                 qneg;
        logic                 rneg;
    } t_pipe;

    function automatic logic [4:0] align_of(t_wc wc);
        logic [4:0] k;
        unique case (wc)
            WC_8:    k = 5'd24;
            WC_16:   k = 5'd16;
            default: k = 5'd0;
        endcase
        return k;
    endfunction

    // one restoring step: shift in next dividend bit, trial subtract
    function automatic t_pipe div_step(t_pipe p);
        t_pipe         q;
        logic [DATA_BITS:0] t;
        q = p;
        t = {p.hi, p.lo[DATA_BITS-1]};
        if (p.kind == K_DIV || p.kind == K_IDIV) begin
            if (t >= {1'b0, p.dv}) begin
                q.hi = DATA_BITS'(t - {1'b0, p.dv});
                q.lo = {p.lo[DATA_BITS-2:0], 1'b1};
            end else begin
                q.hi = t[DATA_BITS-1:0];
                q.lo = {p.lo[DATA_BITS-2:0], 1'b0};
            end
        end
        return q;
    endfunction

    logic  en;
    logic  r_v0, r_v1;
    t_op   r_p0;
    t_pipe r_p1;
    t_pipe n_p1;
    t_pipe n_d0;
    logic  r_vd [DIV_STEPS+1];
    t_pipe r_d  [DIV_STEPS+1];
    logic  r_out_valid;
    t_alu_out r_out;
    t_alu_out n_out;

    assign en      = !r_out_valid || !i_stall;
    assign o_pop   = en && i_valid;
    assign o_valid = r_out_valid;
    assign o_item  = r_out;

    // stage a: add/sub flags, product, divide magnitudes
    logic [DATA_BITS-1:0] m, x, y, r, sa, sb, s, ms, lo_md, hi_md;
    logic                 c, is_sub, is_sgn, cf, af, of, dneg, sneg;
    logic [DATA_BITS:0]   sum;
    logic [DATA_BITS:0]   ma, mb;
    logic [2*DATA_BITS+1:0] prod;
    logic [2*DATA_BITS-1:0] d, md;

    always_comb begin
        m      = wmask(r_p0.wc);
        x      = r_p0.a;
        y      = r_p0.b;
        c      = 1'b0;
        is_sub = 1'b0;
        unique case (r_p0.kind)
            K_ADC:        c = r_p0.fin[F_CF];
            K_SUB, K_CMP: is_sub = 1'b1;
            K_SBB: begin
                is_sub = 1'b1;
                c      = r_p0.fin[F_CF];
            end
            K_INC:        y = DATA_BITS'(1);
            K_DEC: begin
                y      = DATA_BITS'(1);
                is_sub = 1'b1;
            end
            K_NEG: begin
                x      = '0;
                y      = r_p0.a;
                is_sub = 1'b1;
            end
            default: ;
        endcase
        if (is_sub) begin
            sum = {1'b0, x} - {1'b0, y} - (DATA_BITS+1)'(c);
        end else begin
            sum = {1'b0, x} + {1'b0, y} + (DATA_BITS+1)'(c);
        end
        r = sum[DATA_BITS-1:0] & m;
        unique case (r_p0.wc)
            WC_8:    cf = is_sub ? sum[DATA_BITS] : sum[8];
            WC_16:   cf = is_sub ? sum[DATA_BITS] : sum[16];
            default: cf = sum[DATA_BITS];
        endcase
        af = x[4] ^ y[4] ^ r[4];
        of = is_sub ? msb_of((x ^ y) & (x ^ r), r_p0.wc) :
                      msb_of((x ^ r) & (y ^ r), r_p0.wc);

        // signed multiply and divide use width-extended operands
        is_sgn = (r_p0.kind == K_IMUL_W || r_p0.kind == K_IMUL_T ||
                  r_p0.kind == K_IDIV);
        sa   = is_sgn ? sext_w(r_p0.a, r_p0.wc) : r_p0.a;
        sb   = is_sgn ? sext_w(r_p0.b, r_p0.wc) : r_p0.b;
        ma   = {is_sgn & sa[DATA_BITS-1], sa};
        mb   = {is_sgn & sb[DATA_BITS-1], sb};
        prod = $signed(ma) * $signed(mb);

        unique case (r_p0.wc)
            WC_8:    d = {{(2*DATA_BITS-16){is_sgn & r_p0.h[7]}},
                          r_p0.h[7:0], r_p0.a[7:0]};
            WC_16:   d = {{(2*DATA_BITS-32){is_sgn & r_p0.h[15]}},
                          r_p0.h[15:0], r_p0.a[15:0]};
            default: d = {r_p0.h, r_p0.a};
        endcase
        dneg = is_sgn & d[2*DATA_BITS-1];
        md   = dneg ? ((2*DATA_BITS)'(0) - d) : d;
        s    = sb;
        sneg = is_sgn & s[DATA_BITS-1];
        ms   = sneg ? (DATA_BITS'(0) - s) : s;
        // dividend low half goes left-aligned so every width takes all steps
        unique case (r_p0.wc)
            WC_8: begin
                hi_md = {{(DATA_BITS-8){1'b0}}, md[15:8]};
                lo_md = {md[7:0], {(DATA_BITS-8){1'b0}}};
            end
            WC_16: begin
                hi_md = {{(DATA_BITS-16){1'b0}}, md[31:16]};
                lo_md = {md[15:0], {(DATA_BITS-16){1'b0}}};
            end
            default: begin
                hi_md = md[2*DATA_BITS-1:DATA_BITS];
                lo_md = md[DATA_BITS-1:0];
            end
        endcase

        n_p1.kind  = r_p0.kind;
        n_p1.wc    = r_p0.wc;
        n_p1.lo    = '0;
        n_p1.hi    = '0;
        n_p1.dv    = '0;
        n_p1.flags = r_p0.fin;
        n_p1.wr    = 1'b0;
        n_p1.wh    = 1'b0;
        n_p1.de    = 1'b0;
        n_p1.qneg  = 1'b0;
        n_p1.rneg  = 1'b0;
        unique case (r_p0.kind)
            K_ADD, K_ADC, K_SUB, K_SBB, K_CMP, K_INC, K_DEC, K_NEG: begin
                n_p1.lo = r;
                n_p1.wr = (r_p0.kind != K_CMP);
                n_p1.flags[F_CF] = (r_p0.kind == K_INC || r_p0.kind == K_DEC) ?
                                   r_p0.fin[F_CF] : cf;
                n_p1.flags[F_PF] = ~^r[7:0];
                n_p1.flags[F_AF] = af;
                n_p1.flags[F_ZF] = (r == '0);
                n_p1.flags[F_SF] = msb_of(r, r_p0.wc);
                n_p1.flags[F_OF] = of;
            end
            K_MUL, K_IMUL_W, K_IMUL_T: begin
                n_p1.lo = prod[DATA_BITS-1:0];
                n_p1.hi = prod[2*DATA_BITS-1:DATA_BITS];
            end
            K_DIV, K_IDIV: begin
                n_p1.lo   = lo_md;
                n_p1.hi   = hi_md;
                n_p1.dv   = ms;
                n_p1.qneg = dneg ^ sneg;
                n_p1.rneg = dneg;
            end
            default: ;
        endcase
    end

    // stage b: product split and flags, divide overflow screen
    logic [DATA_BITS-1:0] m1, plo, phi;
    logic                 sig;

    always_comb begin
        n_d0 = r_p1;
        m1   = wmask(r_p1.wc);
        unique case (r_p1.wc)
            WC_8:    phi = {{(DATA_BITS-8){1'b0}}, r_p1.lo[15:8]};
            WC_16:   phi = {{(DATA_BITS-16){1'b0}}, r_p1.lo[31:16]};
            default: phi = r_p1.hi;
        endcase
        plo = r_p1.lo & m1;
        sig = (r_p1.kind == K_MUL) ? (phi != '0) :
              (phi != (m1 & {DATA_BITS{msb_of(plo, r_p1.wc)}}));
        unique case (r_p1.kind)
            K_MUL, K_IMUL_W, K_IMUL_T: begin
                n_d0.lo          = plo;
                n_d0.hi          = (r_p1.kind == K_IMUL_T) ? '0 : phi;
                n_d0.wr          = 1'b1;
                n_d0.wh          = (r_p1.kind != K_IMUL_T);
                n_d0.flags[F_CF] = sig;
                n_d0.flags[F_OF] = sig;
            end
            K_DIV, K_IDIV: begin
                // upper half not below divisor means quotient too wide
                n_d0.de = (r_p1.dv == '0) || (r_p1.hi >= r_p1.dv);
                n_d0.dv = r_p1.dv << align_of(r_p1.wc);
            end
            default: ;
        endcase
    end

    // final: undo alignment and signs, signed range check
    t_pipe                f;
    logic [DATA_BITS-1:0] qv, rv, lim, m2;
    logic                 ovf, dev;

    always_comb begin
        f  = r_d[DIV_STEPS];
        m2 = wmask(f.wc);
        qv = f.lo;
        rv = f.hi >> align_of(f.wc);
        unique case (f.wc)
            WC_8:    lim = DATA_BITS'(32'h0000_0080);
            WC_16:   lim = DATA_BITS'(32'h0000_8000);
            default: lim = {1'b1, {(DATA_BITS-1){1'b0}}};
        endcase
        ovf = f.qneg ? (qv > lim) : (qv > lim - DATA_BITS'(1));
        dev = f.de || (f.kind == K_IDIV && ovf);
        n_out.result_low    = f.lo;
        n_out.result_high   = f.hi;
        n_out.flags_out     = f.flags;
        n_out.writes_result = f.wr;
        n_out.writes_high   = f.wh;
        n_out.divide_error  = 1'b0;
        if (f.kind == K_DIV || f.kind == K_IDIV) begin
            if (dev) begin
                n_out.result_low    = '0;
                n_out.result_high   = '0;
                n_out.writes_result = 1'b0;
                n_out.writes_high   = 1'b0;
                n_out.divide_error  = 1'b1;
            end else begin
                n_out.result_low    = (f.qneg ? (DATA_BITS'(0) - qv) : qv) & m2;
                n_out.result_high   = (f.rneg ? (DATA_BITS'(0) - rv) : rv) & m2;
                n_out.writes_result = 1'b1;
                n_out.writes_high   = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0        <= 1'b0;
            r_v1        <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i <= DIV_STEPS; i++) begin
                r_vd[i] <= 1'b0;
            end
        end else if (en) begin
            r_v0        <= i_valid;
            r_v1        <= r_v0;
            r_vd[0]     <= r_v1;
            for (int i = 0; i < DIV_STEPS; i++) begin
                r_vd[i+1] <= r_vd[i];
            end
            r_out_valid <= r_vd[DIV_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p0    <= i_op;
            r_p1    <= n_p1;
            r_d[0]  <= n_d0;
            for (int i = 0; i < DIV_STEPS; i++) begin
                r_d[i+1] <= div_step(r_d[i]);
            end
            r_out   <= n_out;
        end
    end

`ifndef SYNTHESIS
    a_de_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.divide_error |-> !r_out.writes_result && !r_out.writes_high)
        else $error("divide error with write enable");
    a_wh_needs_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.writes_high |-> r_out.writes_result)
        else $error("high write without result write");
    a_hi_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.writes_high |-> r_out.result_high == '0)
        else $error("high result not zero");
    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_vd[DIV_STEPS]))
        else $error("pipeline moved while stalled");
`endif

endmodule

### rtl/x86_integer_alu_with_flags.sv
`timescale 1ns / 1ps
// top level of the x86 integer alu with flags
// depends on xalu_pkg, xalu_front, xalu_queue, xalu_back
//
// one x86 integer operation per item (add, adc, sub, sbb, cmp, inc, dec, neg,
// mul, widening and truncating imul, div, idiv) at 8, 16 or 32 bits; a new item
// is taken every cycle while o_stall is low and one result item leaves every cycle
// while i_stall is low. every item runs the same fixed path: a front register that
// masks operands, a four-entry queue, an operand stage, a product/flag stage, 32
// restoring divide stages (one quotient bit each) and an output register; the
// divide pipeline sets the length of that path. results come out in order.
// undefined flags pass through from flags_in; on a zero divisor or quotient
// overflow divide_error is set and both results read zero
module x86_integer_alu_with_flags (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  xalu_pkg::t_alu_in  i_item,
    output logic               o_valid,
    input  logic               i_stall,
    output xalu_pkg::t_alu_out o_item
);
    import xalu_pkg::*;

    // front to queue
    logic f_valid;
    logic q_stall;
    t_op  f_op;
    // queue to back
    logic q_valid;
    logic b_pop;
    t_op  q_op;

    xalu_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (i_item),
        .o_valid (f_valid),
        .i_stall (q_stall),
        .o_op    (f_op)
    );

    xalu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_stall (q_stall),
        .i_op    (f_op),
        .o_valid (q_valid),
        .i_pop   (b_pop),
        .o_op    (q_op)
    );

    // back end stalls only on the output side
    xalu_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .o_pop   (b_pop),
        .i_op    (q_op),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_item  (o_item)
    );

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// testbench for x86_integer_alu_with_flags: directed and random operations,
// results checked against an in-bench flag and arithmetic predictor
// depends on xalu_pkg and the alu rtl
module testbench;
    import xalu_pkg::*;

    logic     i_clk;
    logic     i_rst_n;
    logic     i_valid;
    logic     o_stall;
    t_alu_in  i_item;
    logic     o_valid;
    logic     i_stall;
    t_alu_out o_item;

    t_alu_in  pending_items[$];
    t_alu_out expected_results[$];
    int       error_count;
    bit       stimulus_done;
    int       send_gap;
    int       recv_gap;
    bit       in_taken;
    bit       out_taken;

    x86_integer_alu_with_flags uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_item  (o_item)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // zf, sf, pf of a masked result
    function automatic logic [5:0] zsp(logic [63:0] r, int bits);
        logic [5:0] f;
        f = '0;
        f[F_PF] = ~^r[7:0];
        f[F_ZF] = (r == 0);
        f[F_SF] = r[bits-1];
        return f;
    endfunction

    function automatic logic [63:0] sx(logic [63:0] v, int n);
        logic [63:0] s;
        if (n >= 64) return v;
        v = v & ((64'd1 << n) - 1);
        s = 64'd1 << (n - 1);
        return (v ^ s) - s;
    endfunction

    // a + b + c or a - b - c with full oszapc flags
    function automatic logic [5:0] arith_flags(logic [63:0] a, logic [63:0] b, logic [63:0] c,
                                               bit subtract, int bits, output logic [63:0] r);
        logic [63:0] m;
        logic [63:0] full;
        logic [5:0]  f;
        m = (64'd1 << bits) - 1;
        full = subtract ? (a - b - c) : (a + b + c);
        r = full & m;
        f = zsp(r, bits);
        f[F_CF] = subtract ? (a < b + c) : (full > m);
        f[F_AF] = 1'((a ^ b ^ r) >> 4);
        f[F_OF] = subtract ? 1'(((a ^ b) & (a ^ r)) >> (bits - 1))
                           : 1'(((a ^ r) & (b ^ r)) >> (bits - 1));
        return f;
    endfunction

    function automatic t_alu_out predict_alu(t_alu_in x);
        t_alu_out    y;
        int          bits;
        logic [63:0] m, a, b, h, lo, hi, p, d, s, md, ms, q, rm, lim;
        logic [5:0]  fo;
        bit          dneg, sneg, qneg;
        bits = (x.width_code == WC_8) ? 8 : (x.width_code == WC_16) ? 16 : 32;
        m  = (64'd1 << bits) - 1;
        a  = x.dest_value & m;
        b  = x.src_value & m;
        h  = x.high_value & m;
        lo = '0;
        hi = '0;
        fo = x.flags_in;
        y  = '0;
        case (x.kind)
            K_ADD: begin
                fo = arith_flags(a, b, 64'd0, 1'b0, bits, lo);
                y.writes_result = 1'b1;
            end
            K_ADC: begin
                fo = arith_flags(a, b, 64'(x.flags_in[F_CF]), 1'b0, bits, lo);
                y.writes_result = 1'b1;
            end
            K_SUB: begin
                fo = arith_flags(a, b, 64'd0, 1'b1, bits, lo);
                y.writes_result = 1'b1;
            end
            K_SBB: begin
                fo = arith_flags(a, b, 64'(x.flags_in[F_CF]), 1'b1, bits, lo);
                y.writes_result = 1'b1;
            end
            K_CMP: fo = arith_flags(a, b, 64'd0, 1'b1, bits, lo);
            K_INC, K_DEC: begin
                // carry is kept
                fo = arith_flags(a, 64'd1, 64'd0, x.kind == K_DEC, bits, lo);
                fo[F_CF] = x.flags_in[F_CF];
                y.writes_result = 1'b1;
            end
            K_NEG: begin
                fo = arith_flags(64'd0, a, 64'd0, 1'b1, bits, lo);
                y.writes_result = 1'b1;
            end
            K_MUL: begin
                p = a * b;
                lo = p & m;
                hi = (p >> bits) & m;
                fo[F_CF] = (hi != 0);
                fo[F_OF] = (hi != 0);
                y.writes_result = 1'b1;
                y.writes_high = 1'b1;
            end
            K_IMUL_W, K_IMUL_T: begin
                p = sx(a, bits) * sx(b, bits);
                lo = p & m;
                fo[F_CF] = (sx(lo, bits) != p);
                fo[F_OF] = (sx(lo, bits) != p);
                y.writes_result = 1'b1;
                if (x.kind == K_IMUL_W) begin
                    hi = (p >> bits) & m;
                    y.writes_high = 1'b1;
                end
            end
            K_DIV: begin
                d = (h << bits) | a;
                if (b == 0 || d / b > m) y.divide_error = 1'b1;
                else begin
                    lo = d / b;
                    hi = d % b;
                    y.writes_result = 1'b1;
                    y.writes_high = 1'b1;
                end
            end
            K_IDIV: begin
                d = sx((h << bits) | a, 2 * bits);
                s = sx(b, bits);
                dneg = d[63];
                sneg = s[63];
                md = dneg ? -d : d;
                ms = sneg ? -s : s;
                lim = 64'd1 << (bits - 1);
                qneg = dneg != sneg;
                if (ms == 0) y.divide_error = 1'b1;
                else begin
                    q = md / ms;
                    rm = md % ms;
                    if (qneg ? (q > lim) : (q > lim - 1)) y.divide_error = 1'b1;
                    else begin
                        lo = (qneg ? -q : q) & m;
                        hi = (dneg ? -rm : rm) & m;
                        y.writes_result = 1'b1;
                        y.writes_high = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        y.result_low  = lo[31:0];
        y.result_high = hi[31:0];
        y.flags_out   = fo;
        return y;
    endfunction

    function automatic logic [31:0] edge_value();
        case ($urandom_range(0, 7))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            4: return 32'h0000_0080;
            5: return 32'h0000_8000;
            6: return $urandom_range(0, 3);
            default: return $urandom;
        endcase
    endfunction

    task automatic push_item(t_kind k, t_wc w, logic [31:0] a, logic [31:0] b,
                             logic [31:0] h, logic [5:0] f);
        t_alu_in x;
        x.kind = k;
        x.width_code = w;
        x.dest_value = a;
        x.src_value = b;
        x.high_value = h;
        x.flags_in = f;
        pending_items.push_back(x);
    endtask

    // stimulus
    initial begin
        t_alu_in     x;
        logic [31:0] bq, hq;
        error_count = 0;
        stimulus_done = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_item  = '0;
        // directed: extremes, every operation, odd width and kind codes
        push_item(K_ADD, WC_32, 32'hFFFF_FFFF, 32'h1, 0, 6'h00);
        push_item(K_ADC, WC_8, 32'h7F, 32'h0, 0, 6'h01);
        push_item(K_SUB, WC_16, 32'h0, 32'h1, 0, 6'h3F);
        push_item(K_SBB, WC_32, 32'h8000_0000, 32'h0, 0, 6'h01);
        push_item(K_CMP, WC_8, 32'h55, 32'h55, 0, 6'h00);
        push_item(K_INC, WC_8, 32'h7F, 0, 0, 6'h01);
        push_item(K_DEC, WC_16, 32'h8000, 0, 0, 6'h00);
        push_item(K_NEG, WC_32, 32'h8000_0000, 0, 0, 6'h00);
        push_item(K_NEG, WC_8, 32'h0, 0, 0, 6'h3F);
        push_item(K_MUL, WC_32, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 6'h00);
        push_item(K_IMUL_W, WC_16, 32'h8000, 32'h8000, 0, 6'h00);
        push_item(K_IMUL_T, WC_8, 32'hFF, 32'h02, 0, 6'h3F);
        push_item(K_DIV, WC_32, 32'h0, 32'h0, 32'h1, 6'h15);
        push_item(K_DIV, WC_8, 32'h00, 32'h01, 32'h01, 6'h00);
        push_item(K_DIV, WC_32, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 6'h00);
        push_item(K_IDIV, WC_32, 32'h0, 32'hFFFF_FFFF, 32'h8000_0000, 6'h00);
        push_item(K_IDIV, WC_8, 32'h80, 32'hFF, 32'hFF, 6'h2A);
        push_item(K_IDIV, WC_16, 32'h8000, 32'hFFFF, 32'hFFFF, 6'h00);
        push_item(K_IDIV, WC_16, 32'hFFF9, 32'h2, 32'hFFFF, 6'h00);
        push_item(4'd13, WC_16, 32'h1234, 32'h1, 0, 6'h2D);
        push_item(4'd15, 2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'h3F);
        push_item(K_ADD, 2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'h3F);
        // random: mostly valid kinds, divides often kept in range
        for (int n = 0; n < 1430; n++) begin
            x.kind = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(13, 15))
                                                  : 4'($urandom_range(0, 12));
            x.width_code = ($urandom_range(0, 15) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
            x.dest_value = $urandom_range(0, 1) ? edge_value() : $urandom;
            x.src_value  = $urandom_range(0, 1) ? edge_value() : $urandom;
            x.high_value = $urandom_range(0, 1) ? edge_value() : $urandom;
            x.flags_in   = 6'($urandom);
            if ((x.kind == K_DIV || x.kind == K_IDIV) && $urandom_range(0, 3) != 0) begin
                // keep the high half below the divisor so the quotient fits
                bq = x.src_value | 32'h1;
                hq = (x.kind == K_DIV) ? (x.high_value % bq) : 32'h0;
                if (x.kind == K_IDIV) begin
                    bq = {1'b0, bq[30:0]} | 32'h1;
                    x.src_value = bq;
                    x.dest_value = {1'b0, x.dest_value[30:0]};
                    hq = '0;
                    if ($urandom_range(0, 1)) begin
                        x.src_value = -bq;
                    end
                end else begin
                    x.src_value = bq;
                end
                x.high_value = hq;
            end
            pending_items.push_back(x);
        end
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        wait (pending_items.size() == 0 && !i_valid);
        wait (expected_results.size() == 0);
        repeat (60) @(posedge i_clk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // driver: changes on the falling edge, random gap per item
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            send_gap <= $urandom_range(0, 12);
        end else if (i_valid && !in_taken) begin
            // hold the item until it is taken
        end else if (send_gap > 0) begin
            i_valid <= 1'b0;
            send_gap <= send_gap - 1;
        end else if (pending_items.size() > 0) begin
            i_item <= pending_items.pop_front();
            i_valid <= 1'b1;
            send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
        end else begin
            i_valid <= 1'b0;
        end
    end

    // stall pattern on the result side, a fresh wait after every result item
    always @(negedge i_clk) begin
        int g;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            recv_gap <= 0;
        end else if (out_taken) begin
            g = $urandom_range(0, 12);
            i_stall <= (g != 0);
            recv_gap <= (g == 0) ? 0 : g - 1;
        end else if (recv_gap > 0) begin
            i_stall <= 1'b1;
            recv_gap <= recv_gap - 1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // accepted input items feed the predictor
    always @(posedge i_clk) begin
        in_taken <= i_rst_n && i_valid && !o_stall;
        if (i_rst_n && i_valid && !o_stall) expected_results.push_back(predict_alu(i_item));
    end

    // monitor: compare each result item with the oldest prediction
    always @(posedge i_clk) begin
        t_alu_out e;
        out_taken <= i_rst_n && o_valid && !i_stall;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_results.size() == 0) begin
                $error("result item with no prediction waiting");
                error_count++;
            end else begin
                e = expected_results.pop_front();
                if (o_item.result_low !== e.result_low) begin
                    $error("result_low exp %h got %h", e.result_low, o_item.result_low);
                    error_count++;
                end
                if (o_item.result_high !== e.result_high) begin
                    $error("result_high exp %h got %h", e.result_high, o_item.result_high);
                    error_count++;
                end
                if (o_item.flags_out !== e.flags_out) begin
                    $error("flags_out exp %h got %h", e.flags_out, o_item.flags_out);
                    error_count++;
                end
                if (o_item.writes_result !== e.writes_result) begin
                    $error("writes_result exp %b got %b", e.writes_result,
                           o_item.writes_result);
                    error_count++;
                end
                if (o_item.writes_high !== e.writes_high) begin
                    $error("writes_high exp %b got %b", e.writes_high, o_item.writes_high);
                    error_count++;
                end
                if (o_item.divide_error !== e.divide_error) begin
                    $error("divide_error exp %b got %b", e.divide_error, o_item.divide_error);
                    error_count++;
                end
            end
        end
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
